>>> sv/fcd_pkg.sv
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared constants for the framed command deframer: header bytes, parse
// phase codes and field widths.
// ----------------------------------------------------------------------------
package fcd_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 256;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 16;
   localparam int unsigned PH_W   = 4;

   localparam logic [BYTE_W-1:0] HDR_A = 8'hAA;
   localparam logic [BYTE_W-1:0] HDR_B = 8'hBB;

   localparam logic [PH_W-1:0] PH_HUNT_A = 4'd0;
   localparam logic [PH_W-1:0] PH_HUNT_B = 4'd1;
   localparam logic [PH_W-1:0] PH_SET    = 4'd2;
   localparam logic [PH_W-1:0] PH_ID     = 4'd3;
   localparam logic [PH_W-1:0] PH_LEN_H  = 4'd4;
   localparam logic [PH_W-1:0] PH_LEN_L  = 4'd5;
   localparam logic [PH_W-1:0] PH_DATA   = 4'd6;
   localparam logic [PH_W-1:0] PH_CK_A   = 4'd7;
   localparam logic [PH_W-1:0] PH_CK_B   = 4'd8;

   // rsp_tuser bit positions
   localparam int unsigned FLAG_PAYLOAD = 0;
   localparam int unsigned FLAG_DONE    = 1;
   localparam int unsigned FLAG_GOOD    = 2;
   localparam int unsigned FLAG_W       = 3;

   localparam int unsigned RSP_DATA_W = 48;

endpackage

>>> sv/framed_command_deframer_unit.sv
// ----------------------------------------------------------------------------
// framed_command_deframer_unit
// Hunts for the 0xAA 0xBB header, captures command set, id and length,
// streams payload bytes with their index and checks the Fletcher-8 trailer.
// The response is registered and appears in the cycle after the request is accepted.
// Throughput: 1 byte per cycle; only the response register can stall input.
// Reset: synchronous; returns to header hunt with captured fields and sums zero.
// ----------------------------------------------------------------------------
module framed_command_deframer_unit #(
   parameter int unsigned MAX_PAYLOAD = fcd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fcd_pkg::BYTE_W-1:0]        req_tdata,  // [7:0] rx_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] payload_byte, [15:8] payload_index, [23:16] command_set,
   // [31:24] command_id, [47:32] frame_length
   output logic [fcd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] payload_valid, [1] frame_done, [2] frame_good
   output logic [fcd_pkg::FLAG_W-1:0]        rsp_tuser
);
   import fcd_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

   logic                  accept;
   logic [PH_W-1:0]       phase_ff, phase_in;
   logic [BYTE_W-1:0]     set_ff, set_in;
   logic [BYTE_W-1:0]     id_ff, id_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [BYTE_W-1:0]     sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0]     sum_b_ff, sum_b_in;
   logic [BYTE_W-1:0]     rx_a_ff, rx_a_in;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [FLAG_W-1:0]     rsp_user_ff, rsp_user_in;

   logic [BYTE_W-1:0]     b;
   logic [BYTE_W-1:0]     fa, fb;
   logic [LEN_W-1:0]      taken_len;
   logic [CNT_W-1:0]      cnt_inc;
   logic [CNT_W+7:0]      cnt_wide;
   logic                  pv, done, good;
   logic [BYTE_W-1:0]     pb, pidx;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign b          = req_tdata;

   // Fletcher-8 step on the incoming byte
   assign fa = sum_a_ff + b;
   assign fb = sum_b_ff + fa;

   assign taken_len = (32'(len_ff) > 32'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : len_ff;
   assign cnt_inc   = cnt_ff + CNT_W'(1);
   assign cnt_wide  = {8'd0, cnt_ff};

   always_comb begin
      phase_in = phase_ff;
      set_in   = set_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      rx_a_in  = rx_a_ff;
      pv       = 1'b0;
      pb       = '0;
      pidx     = '0;
      done     = 1'b0;
      good     = 1'b0;
      case (phase_ff)
         PH_HUNT_A: begin
            if (b == HDR_A) phase_in = PH_HUNT_B;
         end
         PH_HUNT_B: begin
            if (b == HDR_B) begin
               phase_in = PH_SET;
               sum_a_in = '0;
               sum_b_in = '0;
            end else if (b != HDR_A) begin
               phase_in = PH_HUNT_A;
            end
         end
         PH_SET: begin
            set_in   = b;
            sum_a_in = fa;
            sum_b_in = fb;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = b;
            sum_a_in = fa;
            sum_b_in = fb;
            phase_in = PH_LEN_H;
         end
         PH_LEN_H: begin
            len_in   = {b, 8'd0};
            sum_a_in = fa;
            sum_b_in = fb;
            cnt_in   = '0;
            phase_in = PH_LEN_L;
         end
         PH_LEN_L: begin
            len_in   = {len_ff[LEN_W-1:8], b};
            sum_a_in = fa;
            sum_b_in = fb;
            cnt_in   = '0;
            phase_in = ({len_ff[LEN_W-1:8], b} == '0) ? PH_CK_A : PH_DATA;
         end
         PH_DATA: begin
            pv       = 1'b1;
            pb       = b;
            pidx     = cnt_wide[7:0];
            sum_a_in = fa;
            sum_b_in = fb;
            cnt_in   = cnt_inc;
            if (17'(cnt_inc) >= 17'(taken_len)) phase_in = PH_CK_A;
         end
         PH_CK_A: begin
            rx_a_in  = b;
            phase_in = PH_CK_B;
         end
         PH_CK_B: begin
            done     = 1'b1;
            good     = (rx_a_ff == sum_a_ff) && (b == sum_b_ff);
            phase_in = PH_HUNT_A;
         end
         default: begin
            phase_in = PH_HUNT_A;
         end
      endcase
   end

   always_comb begin
      rsp_data_in = {len_in, id_in, set_in, pidx, pb};
      rsp_user_in = '0;
      rsp_user_in[FLAG_PAYLOAD] = pv;
      rsp_user_in[FLAG_DONE]    = done;
      rsp_user_in[FLAG_GOOD]    = good;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT_A;
         set_ff   <= '0;
         id_ff    <= '0;
         len_ff   <= '0;
         cnt_ff   <= '0;
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         rx_a_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         set_ff   <= set_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         rx_a_ff  <= rx_a_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // good only ever comes with done
   a_good_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[FLAG_GOOD] |-> rsp_tuser[FLAG_DONE])
      else $error("frame_good without frame_done");

   a_payload_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[FLAG_PAYLOAD] && rsp_tuser[FLAG_DONE]))
      else $error("payload and frame end flagged together");

   a_ckb_returns: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_CK_B |=> phase_ff == PH_HUNT_A)
      else $error("no return to hunt after checksum");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> 32'(cnt_ff) < 32'(MAX_PAYLOAD))
      else $error("payload count beyond limit");

   a_data_entry: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_LEN_L |=> cnt_ff == '0)
      else $error("payload count not cleared at length");

endmodule
